[hdl/monotone_chain_hull_core_macros.svh]
// Assertion macros shared by the hull core RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef MONOTONE_CHAIN_HULL_CORE_MACROS_SVH
`define MONOTONE_CHAIN_HULL_CORE_MACROS_SVH

// Same-cycle implication, masked while in reset
`define MCH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while in reset
`define MCH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mch_pkg.sv]
// Shared types and constants of the monotone chain hull core.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package mch_pkg;

  // Fixed widths of the request and result fields
  localparam int unsigned CoordW = 32;
  localparam int unsigned VidxW  = 6;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [VidxW-1:0]  vidx_t;

  // One point of a set
  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   final_point;
  } point_t;

  // One hull vertex
  typedef struct packed {
    coord_t hull_x;
    coord_t hull_y;
    vidx_t  vertex_index;
    logic   last_vertex;
    logic   overflowed;
  } vertex_t;

endpackage

`default_nettype wire

[hdl/mch_if.sv]
// Valid/ready channel interfaces for points in and hull vertices out.
// Depends on mch_pkg for the payload types.
`default_nettype none

interface mch_point_if;
  logic            valid;
  logic            ready;
  mch_pkg::point_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mch_vertex_if;
  logic             valid;
  logic             ready;
  mch_pkg::vertex_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/monotone_chain_hull_core.sv]
// Upper convex hull (monotone chain) core: stack in on-chip RAM, top two cached.
// Depends on mch_pkg, mch_if.sv and monotone_chain_hull_core_macros.svh.
// Takes a new point only once the previous point and any hull read-out are done; points
// below two entries are pushed without a compare, and a pop reloads the second entry from
// RAM when three or more were stacked. After a final point the vertices are read out through
// the one RAM read port as the output frees up; reset clears control, not the RAM.
`default_nettype none

`include "monotone_chain_hull_core_macros.svh"

module monotone_chain_hull_core #(
  parameter int unsigned HULL_DEPTH = 64,
  parameter int unsigned COORD_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  mch_point_if.sink       point_i,
  mch_vertex_if.source    vertex_o
);

  localparam int unsigned IdxW  = (HULL_DEPTH > 1) ? $clog2(HULL_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(HULL_DEPTH + 1);
  localparam int unsigned DiffW = COORD_BITS + 1;
  localparam int unsigned ProdW = 2 * DiffW;
  localparam int unsigned VidxW = mch_pkg::VidxW;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_CAP  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic ovf_q, ovf_d;
  logic [IdxW-1:0] k_q, k_d;
  logic out_valid_q, out_valid_d;
  mch_pkg::vertex_t out_q, out_d;

  // Current point and cached top two entries
  logic signed [COORD_BITS-1:0] pt_x_q, pt_y_q;
  logic fin_q;
  logic signed [COORD_BITS-1:0] top_x_q, top_y_q, sec_x_q, sec_y_q;

  // Cross product pipeline
  logic signed [DiffW-1:0] dbx_q, dby_q, dcx_q, dcy_q;
  logic signed [ProdW-1:0] prod_p_q, prod_q_q;

  // Stack RAM
  logic signed [COORD_BITS-1:0] mem_x [HULL_DEPTH];
  logic signed [COORD_BITS-1:0] mem_y [HULL_DEPTH];
  logic signed [COORD_BITS-1:0] rd_x_q, rd_y_q;
  logic wr_en, rd_en;
  logic [IdxW-1:0] rd_addr;

  logic accept, push_en, pop_en, turn_ge, out_free, is_last, stack_full;
  logic [CntW-1:0] k_next;

  assign accept     = point_i.valid && point_i.ready;
  assign turn_ge    = (prod_p_q >= prod_q_q);
  assign out_free   = !out_valid_q || vertex_o.ready;
  assign k_next     = CntW'(k_q) + CntW'(1);
  assign is_last    = (k_next == cnt_q);
  assign stack_full = (cnt_q == CntW'(HULL_DEPTH));
  assign wr_en      = push_en && !stack_full;

  assign point_i.ready  = (state_q == S_IDLE);
  assign vertex_o.valid = out_valid_q;
  assign vertex_o.data  = out_q;

  // Sequence compare, pop, push and emission
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    k_d         = k_q;
    push_en     = 1'b0;
    pop_en      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = k_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !vertex_o.ready;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        if (cnt_q < CntW'(2)) begin
          push_en = 1'b1;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (turn_ge) begin
          pop_en = 1'b1;
          cnt_d  = cnt_q - CntW'(1);
          if (cnt_q >= CntW'(3)) begin
            rd_en   = 1'b1;
            rd_addr = IdxW'(cnt_q - CntW'(3));
            state_d = S_LOAD;
          end else begin
            state_d = S_DIFF;
          end
        end else begin
          push_en = 1'b1;
        end
      end
      S_LOAD: begin
        state_d = S_DIFF;
      end
      S_RD: begin
        if (out_free) begin
          rd_en   = 1'b1;
          state_d = S_CAP;
        end
      end
      S_CAP: begin
        out_valid_d        = 1'b1;
        out_d.hull_x       = mch_pkg::coord_t'(rd_x_q);
        out_d.hull_y       = mch_pkg::coord_t'(rd_y_q);
        out_d.vertex_index = VidxW'(k_q);
        out_d.last_vertex  = is_last;
        out_d.overflowed   = ovf_q;
        if (is_last) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end else begin
          k_d     = IdxW'(k_next);
          state_d = S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Push the point, or drop it when the stack is full
    if (push_en) begin
      if (stack_full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
      k_d     = '0;
      state_d = fin_q ? S_RD : S_IDLE;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      pt_x_q <= point_i.data.px[COORD_BITS-1:0];
      pt_y_q <= point_i.data.py[COORD_BITS-1:0];
      fin_q  <= point_i.data.final_point;
    end
    if (state_q == S_DIFF) begin
      dbx_q <= DiffW'(top_x_q) - DiffW'(sec_x_q);
      dby_q <= DiffW'(top_y_q) - DiffW'(sec_y_q);
      dcx_q <= DiffW'(pt_x_q) - DiffW'(sec_x_q);
      dcy_q <= DiffW'(pt_y_q) - DiffW'(sec_y_q);
    end
    if (state_q == S_MUL) begin
      prod_p_q <= dbx_q * dcy_q;
      prod_q_q <= dby_q * dcx_q;
    end
    // Shift the cache down on a push, up on a pop, refill second from RAM
    if (wr_en) begin
      sec_x_q <= top_x_q;
      sec_y_q <= top_y_q;
      top_x_q <= pt_x_q;
      top_y_q <= pt_y_q;
    end else if (pop_en) begin
      top_x_q <= sec_x_q;
      top_y_q <= sec_y_q;
    end else if (state_q == S_LOAD) begin
      sec_x_q <= rd_x_q;
      sec_y_q <= rd_y_q;
    end
  end

  // Stack RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[cnt_q[IdxW-1:0]] <= pt_x_q;
      mem_y[cnt_q[IdxW-1:0]] <= pt_y_q;
    end
    if (rd_en) begin
      rd_x_q <= mem_x[rd_addr];
      rd_y_q <= mem_y[rd_addr];
    end
  end

  // Checks
  `MCH_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntW'(HULL_DEPTH), "stack count above depth")
  `MCH_ASSERT_IMP(a_ram_port, rd_en, !wr_en, "RAM read and write in the same cycle")
  `MCH_ASSERT_IMP(a_emit_range, state_q == S_RD && rd_en, CntW'(k_q) < cnt_q,
                  "emission reads past the stack top")
  `MCH_ASSERT_NXT(a_set_clear, state_q == S_CAP && is_last, cnt_q == '0 && !ovf_q,
                  "stack not cleared after the last vertex")

endmodule

`default_nettype wire

[bench/tb_monotone_chain_hull_core.sv]
// Self-checking bench for monotone_chain_hull_core: sends point sets, predicts the upper hull.
// Depends on mch_pkg, the channel interfaces in mch_if.sv and the core itself.
`default_nettype none

module tb_monotone_chain_hull_core;

  localparam int              HULL_DEPTH = 64;
  localparam mch_pkg::coord_t CMIN = {1'b1, {(mch_pkg::CoordW-1){1'b0}}};
  localparam mch_pkg::coord_t CMAX = {1'b0, {(mch_pkg::CoordW-1){1'b1}}};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mch_point_if  point_bus ();
  mch_vertex_if vertex_bus ();

  monotone_chain_hull_core #(
    .HULL_DEPTH (HULL_DEPTH),
    .COORD_BITS (mch_pkg::CoordW)
  ) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (point_bus),
    .vertex_o (vertex_bus)
  );

  always #5 clk_i = ~clk_i;

  // Predicted hull stack and the vertices still owed by the core
  mch_pkg::coord_t  hull_x_stk [HULL_DEPTH];
  mch_pkg::coord_t  hull_y_stk [HULL_DEPTH];
  int               hull_cnt;
  bit               hull_ovf;
  mch_pkg::vertex_t pending_vertices [$];
  mch_pkg::vertex_t owed_vertex;
  mch_pkg::point_t  set_buf [$];
  int unsigned      mismatch_count;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;

  // Advance the predicted stack by one accepted point; queue the chain on a final point
  task automatic predict_hull_step(input mch_pkg::point_t pt);
    logic signed [67:0] ax, ay, bx, by, cx, cy, lhs, rhs;
    mch_pkg::vertex_t v;
    bit      popping;
    cx = $signed(pt.px);
    cy = $signed(pt.py);
    popping = 1'b1;
    // Pop while the turn is not strictly clockwise
    while (popping && hull_cnt >= 2) begin
      ax  = hull_x_stk[hull_cnt-2];
      ay  = hull_y_stk[hull_cnt-2];
      bx  = hull_x_stk[hull_cnt-1];
      by  = hull_y_stk[hull_cnt-1];
      lhs = (bx - ax) * (cy - ay);
      rhs = (by - ay) * (cx - ax);
      if (lhs >= rhs) begin
        hull_cnt--;
      end else begin
        popping = 1'b0;
      end
    end
    // Push, or drop the point when the stack is full
    if (hull_cnt < HULL_DEPTH) begin
      hull_x_stk[hull_cnt] = pt.px;
      hull_y_stk[hull_cnt] = pt.py;
      hull_cnt++;
    end else begin
      hull_ovf = 1'b1;
    end
    if (pt.final_point) begin
      for (int k = 0; k < hull_cnt; k++) begin
        v.hull_x       = hull_x_stk[k];
        v.hull_y       = hull_y_stk[k];
        v.vertex_index = mch_pkg::vidx_t'(k);
        v.last_vertex  = (k == hull_cnt - 1);
        v.overflowed   = hull_ovf;
        pending_vertices.push_back(v);
      end
      hull_cnt = 0;
      hull_ovf = 1'b0;
    end
  endtask

  // Drive ready at random and check every accepted vertex against the oldest prediction
  always @(posedge clk_i) begin
    vertex_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && vertex_bus.valid && vertex_bus.ready) begin
      if (pending_vertices.size() == 0) begin
        $display("%0t: unexpected vertex: expected none, got x=%0d y=%0d idx=%0d last=%0b ovf=%0b",
                 $time, $signed(vertex_bus.data.hull_x), $signed(vertex_bus.data.hull_y),
                 vertex_bus.data.vertex_index, vertex_bus.data.last_vertex,
                 vertex_bus.data.overflowed);
        mismatch_count++;
      end else begin
        owed_vertex = pending_vertices.pop_front();
        if (vertex_bus.data !== owed_vertex) begin
          $display("%0t: vertex mismatch: expected x=%0d y=%0d idx=%0d last=%0b ovf=%0b",
                   $time, $signed(owed_vertex.hull_x), $signed(owed_vertex.hull_y),
                   owed_vertex.vertex_index, owed_vertex.last_vertex, owed_vertex.overflowed);
          $display("%0t:                 actual x=%0d y=%0d idx=%0d last=%0b ovf=%0b",
                   $time, $signed(vertex_bus.data.hull_x), $signed(vertex_bus.data.hull_y),
                   vertex_bus.data.vertex_index, vertex_bus.data.last_vertex,
                   vertex_bus.data.overflowed);
          mismatch_count++;
        end
      end
    end
  end

  function automatic mch_pkg::point_t mk_point(input mch_pkg::coord_t x,
                                               input mch_pkg::coord_t y, input bit fin);
    mch_pkg::point_t p;
    p.px          = x;
    p.py          = y;
    p.final_point = fin;
    return p;
  endfunction

  // Span 0 gives the full signed range, otherwise -span..span
  function automatic mch_pkg::coord_t rand_coord(input int unsigned span);
    if (span == 0) return mch_pkg::coord_t'($urandom());
    return mch_pkg::coord_t'(int'($urandom_range(2 * span, 0)) - int'(span));
  endfunction

  function automatic int unsigned pick_span();
    case ($urandom_range(3))
      0:       return 2;
      1:       return 50;
      2:       return 100000;
      default: return 1 << 30;
    endcase
  endfunction

  // Hold valid until the core takes the request, idling beforehand at random
  task automatic send_point(input mch_pkg::point_t pt);
    while ($urandom_range(99) < send_idle_pct) begin
      point_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    point_bus.valid <= 1'b1;
    point_bus.data  <= pt;
    do @(posedge clk_i); while (!point_bus.ready);
    predict_hull_step(pt);
  endtask

  task automatic send_set();
    foreach (set_buf[i]) send_point(set_buf[i]);
    set_buf.delete();
  endtask

  // Hold off the sender until the core has delivered every owed vertex
  task automatic wait_all_vertices();
    point_bus.valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_sorted_set(input int unsigned n, input int unsigned xspan,
                                 input int unsigned yspan);
    mch_pkg::coord_t xs [$];
    repeat (n) xs.push_back(rand_coord(xspan));
    xs.sort();
    foreach (xs[i]) set_buf.push_back(mk_point(xs[i], rand_coord(yspan), i == n - 1));
  endtask

  task automatic load_unsorted_set(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      set_buf.push_back(mk_point(rand_coord(pick_span()), rand_coord(pick_span()), i == n - 1));
    end
  endtask

  // Strictly concave chain: every point stays; optionally end on a spike that pops most of it
  task automatic load_concave_chain(input int unsigned n, input bit spike_end);
    longint cx, cy, slope, dx;
    mch_pkg::point_t pt;
    cx    = rand_coord(1 << 30);
    cy    = rand_coord(1 << 29);
    slope = longint'($urandom_range(8192)) - 4096;
    for (int i = 0; i < n; i++) begin
      pt = mk_point(mch_pkg::coord_t'(cx), mch_pkg::coord_t'(cy), i == n - 1);
      if (spike_end && i == n - 1) pt.py = CMAX;
      set_buf.push_back(pt);
      dx     = $urandom_range(1000, 1);
      cx    += dx;
      cy    += slope * dx;
      slope -= $urandom_range(16, 1);
    end
  endtask

  // Sets of one and two points, and a pair of identical points
  task automatic test_small_sets();
    set_buf.push_back(mk_point(5, 7, 1'b1));
    set_buf.push_back(mk_point(-3, 1, 1'b0));
    set_buf.push_back(mk_point(4, -2, 1'b1));
    set_buf.push_back(mk_point(9, 9, 1'b0));
    set_buf.push_back(mk_point(9, 9, 1'b1));
    send_set();
  endtask

  // Corner coordinates, where the cross product needs its full width
  task automatic test_extreme_coords();
    set_buf.push_back(mk_point(CMIN, CMIN, 1'b0));
    set_buf.push_back(mk_point(0, CMAX, 1'b0));
    set_buf.push_back(mk_point(CMAX, CMIN, 1'b1));
    set_buf.push_back(mk_point(CMIN, CMAX, 1'b0));
    set_buf.push_back(mk_point(0, CMIN, 1'b0));
    set_buf.push_back(mk_point(CMAX, CMAX, 1'b1));
    set_buf.push_back(mk_point(CMIN, 0, 1'b0));
    set_buf.push_back(mk_point(-1, -1, 1'b0));
    set_buf.push_back(mk_point(CMAX, CMAX, 1'b1));
    set_buf.push_back(mk_point(CMAX, CMIN, 1'b1));
    send_set();
  endtask

  // A collinear run, and a vertical pair that shares one x
  task automatic test_collinear_and_duplicates();
    set_buf.push_back(mk_point(0, 0, 1'b0));
    set_buf.push_back(mk_point(1, 1, 1'b0));
    set_buf.push_back(mk_point(2, 2, 1'b0));
    set_buf.push_back(mk_point(3, 3, 1'b1));
    set_buf.push_back(mk_point(0, 0, 1'b0));
    set_buf.push_back(mk_point(0, 10, 1'b0));
    set_buf.push_back(mk_point(5, 0, 1'b1));
    send_set();
  endtask

  // x out of order: the same pop rule still applies
  task automatic test_unsorted_points();
    set_buf.push_back(mk_point(10, 0, 1'b0));
    set_buf.push_back(mk_point(0, 5, 1'b0));
    set_buf.push_back(mk_point(5, 5, 1'b0));
    set_buf.push_back(mk_point(-4, -4, 1'b1));
    send_set();
  endtask

  // Fill the stack exactly, overrun it, and overrun it then pop on the last point
  task automatic test_stack_overflow();
    load_concave_chain(HULL_DEPTH, 1'b0);
    send_set();
    load_concave_chain(HULL_DEPTH + 2, 1'b0);
    send_set();
    load_concave_chain(HULL_DEPTH + 6, 1'b1);
    send_set();
  endtask

  // Mostly sorted sets with random content, some deep chains, some noise
  task automatic test_random_sets(input int unsigned point_budget);
    int unsigned sent, kind;
    sent = 0;
    while (sent < point_budget) begin
      kind = $urandom_range(99);
      if (kind < 2) begin
        load_concave_chain($urandom_range(HULL_DEPTH + 6, HULL_DEPTH - 2), $urandom_range(1));
      end else if (kind < 15) begin
        load_concave_chain($urandom_range(20, 3), $urandom_range(1));
      end else if (kind < 30) begin
        load_sorted_set($urandom_range(8, 1), 0, 0);
      end else if (kind < 40) begin
        load_unsorted_set($urandom_range(8, 1));
      end else begin
        load_sorted_set($urandom_range(12, 1), pick_span(), pick_span());
      end
      sent += set_buf.size();
      send_set();
    end
  endtask

  initial begin
    hull_cnt         = 0;
    hull_ovf         = 1'b0;
    mismatch_count   = 0;
    send_idle_pct    = 19;
    recv_idle_pct    = 77;
    point_bus.valid  <= 1'b0;
    point_bus.data   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_small_sets();
    test_extreme_coords();
    test_collinear_and_duplicates();
    test_unsorted_points();
    test_random_sets(90);
    wait_all_vertices();

    send_idle_pct = 77;
    recv_idle_pct = 19;
    test_random_sets(90);
    wait_all_vertices();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_stack_overflow();
    test_random_sets(60);
    wait_all_vertices();

    // Let any stray vertex surface before judging
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0 && pending_vertices.size() == 0) begin
      $display("** monotone_chain_hull_core: PASSED **");
    end else begin
      $display("** monotone_chain_hull_core: FAILED **");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5000000;
    $display("** monotone_chain_hull_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/mch_pkg.sv
hdl/mch_if.sv
hdl/monotone_chain_hull_core.sv
bench/tb_monotone_chain_hull_core.sv
